### rtl/assert_macros.svh
// Assertion helpers used by the RTL converter core.
// The macros expect a signal named clk, and ASSERT_CLK also one named rst_n, in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/cddn_pkg.sv
`timescale 1ns / 1ps

package cddn_pkg;

  // Range of the calendar that the converter handles.
  localparam logic [15:0] FIRST_YEAR     = 16'd1970;
  localparam logic [15:0] LAST_YEAR      = 16'd2099;
  localparam logic [15:0] MAX_DAY_NUMBER = 16'd47481;

  // Days in a common year and in one four-year leap cycle.
  localparam logic [8:0]  DAYS_YEAR  = 9'd365;
  localparam logic [10:0] CYCLE_DAYS = 11'd1461;

  // Reciprocal of the cycle length: floor(2^21 / 1461). It never overestimates
  // the quotient and underestimates it by at most one over the valid range.
  localparam logic [10:0] CYCLE_RECIP       = 11'd1435;
  localparam int          CYCLE_RECIP_SHIFT = 21;

  // Month and day of month handed back by the month splitter.
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } cddn_date_t;

  // Length of month m (1 is January); February gets its extra day in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days of a common year that come before the first of month m.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/cddn_month_split.sv
`timescale 1ns / 1ps

module cddn_month_split (
  input  logic [8:0]           doy,
  input  logic                 leap,
  output cddn_pkg::cddn_date_t date
);
  import cddn_pkg::*;

  logic [8:0] thr;
  logic [8:0] sel_thr;
  logic [3:0] sel_month;

  // Every month start is compared at once; the latest start not beyond the
  // day of year gives the month.
  always_comb begin
    sel_thr   = '0;
    sel_month = 4'd1;
    thr       = '0;
    for (int k = 2; k <= 12; k++) begin
      thr = cum_days(4'(k)) + 9'(leap && (k > 2));
      if (doy >= thr) begin
        sel_month = 4'(k);
        sel_thr   = thr;
      end
    end
  end

  // Day of month counts from one.
  assign date.month = sel_month;
  assign date.day   = 5'(doy - sel_thr + 9'd1);

endmodule

### rtl/civil_date_day_number_convert_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts between a calendar date (1970-01-01 to 2099-12-31, every year
// divisible by four a leap year) and the zero-based day number counted from
// 1 January 1970; in_tuser picks the direction. A request is accepted in every
// cycle in which in_tready is high, and its result leaves a four-stage
// pipeline: range checks and the two small multiplications, then the day sum
// or the leap-cycle division, then the year inside the cycle, then the month
// split into the output register. The whole pipeline advances together, so
// in_tready drops in the same cycle as a held result meets out_tready low.
// An invalid date or a day number above 47481 gives error set and all other
// result fields zero.
module civil_date_day_number_convert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // day [4:0], month [8:5], year [24:9], day_count [40:25], zero fill
  input  logic [47:0] in_tdata,
  // action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day_number [15:0], out_day [20:16], out_month [24:21], out_year [36:25], zero fill
  output logic [39:0] out_tdata,
  // error
  output logic        out_tuser
);
  import cddn_pkg::*;

  // Unpacked request fields.
  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [15:0] in_year;
  logic [15:0] in_cnt;

  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[24:9];
  assign in_cnt   = in_tdata[40:25];

  // The pipeline moves as one whenever the output register can take a result.
  logic adv;
  logic out_v_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  // Stage 1: checks, year offset times 365 and the cycle quotient estimate.
  logic        s1_v_r, s1_v_nxt;
  logic        s1_act_r;
  logic        s1_err_r, s1_err_nxt;
  logic [7:0]  s1_yo_r, s1_yo_nxt;
  logic [3:0]  s1_m_r;
  logic [4:0]  s1_d_r;
  logic        s1_leap_r, s1_leap_nxt;
  logic [15:0] s1_p365_r, s1_p365_nxt;
  logic [15:0] s1_cnt_r;
  logic [5:0]  s1_qe_r, s1_qe_nxt;

  logic [15:0] yo_w;
  logic [16:0] p365_w;
  logic [26:0] qprod_w;
  logic        date_bad;

  always_comb begin
    s1_v_nxt    = in_tvalid;
    s1_leap_nxt = (in_year[1:0] == 2'd0);
    yo_w        = in_year - FIRST_YEAR;
    s1_yo_nxt   = yo_w[7:0];
    date_bad    = (in_year < FIRST_YEAR) || (in_year > LAST_YEAR) ||
                  (in_month < 4'd1) || (in_month > 4'd12) ||
                  (in_day < 5'd1) || (in_day > month_len(in_month, s1_leap_nxt));
    s1_err_nxt  = in_tuser ? (in_cnt > MAX_DAY_NUMBER) : date_bad;
    p365_w      = 17'(s1_yo_nxt) * 17'(DAYS_YEAR);
    s1_p365_nxt = p365_w[15:0];
    qprod_w     = 27'(in_cnt) * 27'(CYCLE_RECIP);
    s1_qe_nxt   = 6'(qprod_w >> CYCLE_RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r  <= in_tuser;
      s1_err_r  <= s1_err_nxt;
      s1_yo_r   <= s1_yo_nxt;
      s1_m_r    <= in_month;
      s1_d_r    <= in_day;
      s1_leap_r <= s1_leap_nxt;
      s1_p365_r <= s1_p365_nxt;
      s1_cnt_r  <= in_cnt;
      s1_qe_r   <= s1_qe_nxt;
    end
  end

  // Stage 2: the day number of a date, or the exact cycle and its remainder.
  logic        s2_v_r;
  logic        s2_act_r;
  logic        s2_err_r;
  logic [15:0] s2_num_r, s2_num_nxt;
  logic [11:0] s2_year_r, s2_year_nxt;
  logic [3:0]  s2_m_r;
  logic [4:0]  s2_d_r;
  logic [5:0]  s2_q_r, s2_q_nxt;
  logic [10:0] s2_rem_r, s2_rem_nxt;

  logic [16:0] dnum_w;
  logic [16:0] qx_w;
  logic [11:0] r0_w;

  always_comb begin
    dnum_w = 17'(s1_p365_r) + 17'((9'(s1_yo_r) + 9'd1) >> 2) + 17'(cum_days(s1_m_r)) +
             17'(s1_leap_r && (s1_m_r > 4'd2)) + 17'(s1_d_r) - 17'd1;
    qx_w   = 17'(s1_qe_r) * 17'(CYCLE_DAYS);
    r0_w   = 12'(s1_cnt_r - qx_w[15:0]);
    // The estimate falls short by at most one cycle.
    if (r0_w >= 12'(CYCLE_DAYS)) begin
      s2_q_nxt   = s1_qe_r + 6'd1;
      s2_rem_nxt = 11'(r0_w - 12'(CYCLE_DAYS));
    end else begin
      s2_q_nxt   = s1_qe_r;
      s2_rem_nxt = r0_w[10:0];
    end
    s2_num_nxt  = s1_act_r ? s1_cnt_r : dnum_w[15:0];
    s2_year_nxt = FIRST_YEAR[11:0] + 12'(s1_yo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_act_r  <= s1_act_r;
      s2_err_r  <= s1_err_r;
      s2_num_r  <= s2_num_nxt;
      s2_year_r <= s2_year_nxt;
      s2_m_r    <= s1_m_r;
      s2_d_r    <= s1_d_r;
      s2_q_r    <= s2_q_nxt;
      s2_rem_r  <= s2_rem_nxt;
    end
  end

  // Stage 3: year inside the cycle (the third year of each cycle is the leap year).
  logic        s3_v_r;
  logic        s3_act_r;
  logic        s3_err_r;
  logic [15:0] s3_num_r;
  logic [11:0] s3_year_r, s3_year_nxt;
  logic [3:0]  s3_m_r;
  logic [4:0]  s3_d_r;
  logic [8:0]  s3_doy_r, s3_doy_nxt;
  logic        s3_leap_r, s3_leap_nxt;

  logic [1:0]  yic_w;

  always_comb begin
    s3_leap_nxt = 1'b0;
    if (s2_rem_r < 11'd365) begin
      yic_w      = 2'd0;
      s3_doy_nxt = s2_rem_r[8:0];
    end else if (s2_rem_r < 11'd730) begin
      yic_w      = 2'd1;
      s3_doy_nxt = 9'(s2_rem_r - 11'd365);
    end else if (s2_rem_r < 11'd1096) begin
      yic_w       = 2'd2;
      s3_doy_nxt  = 9'(s2_rem_r - 11'd730);
      s3_leap_nxt = 1'b1;
    end else begin
      yic_w      = 2'd3;
      s3_doy_nxt = 9'(s2_rem_r - 11'd1096);
    end
    if (s2_act_r) begin
      s3_year_nxt = FIRST_YEAR[11:0] + 12'({s2_q_r, 2'b00}) + 12'(yic_w);
    end else begin
      s3_year_nxt = s2_year_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_act_r  <= s2_act_r;
      s3_err_r  <= s2_err_r;
      s3_num_r  <= s2_num_r;
      s3_year_r <= s3_year_nxt;
      s3_m_r    <= s2_m_r;
      s3_d_r    <= s2_d_r;
      s3_doy_r  <= s3_doy_nxt;
      s3_leap_r <= s3_leap_nxt;
    end
  end

  // Stage 4: month split and the output register; an error clears every field.
  cddn_date_t split;

  cddn_month_split u_month_split (
    .doy  (s3_doy_r),
    .leap (s3_leap_r),
    .date (split)
  );

  logic [15:0] out_num_r, out_num_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [11:0] out_year_r, out_year_nxt;
  logic        out_err_r;

  always_comb begin
    if (s3_err_r) begin
      out_num_nxt   = '0;
      out_day_nxt   = '0;
      out_month_nxt = '0;
      out_year_nxt  = '0;
    end else begin
      out_num_nxt   = s3_num_r;
      out_year_nxt  = s3_year_r;
      out_day_nxt   = s3_act_r ? split.day : s3_d_r;
      out_month_nxt = s3_act_r ? split.month : s3_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_num_r   <= out_num_nxt;
      out_day_r   <= out_day_nxt;
      out_month_r <= out_month_nxt;
      out_year_r  <= out_year_nxt;
      out_err_r   <= s3_err_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_year_r, out_month_r, out_day_r, out_num_r};
  assign out_tuser  = out_err_r;

  // Checks on the pipeline and its results.
  `ASSERT_CLK(a_err_zero, out_tvalid && out_tuser |-> out_tdata == 40'd0, "error result carries data")
  `ASSERT_CLK(a_month_ok, out_tvalid && !out_tuser |-> out_month_r >= 4'd1 && out_month_r <= 4'd12, "month out of range")
  `ASSERT_CLK(a_year_ok, out_tvalid && !out_tuser |-> out_year_r >= 12'd1970 && out_year_r <= 12'd2099, "year out of range")
  `ASSERT_CLK(a_stall, out_tvalid && !out_tready |-> !in_tready, "request taken while result held")
  `ASSERT_CLK(a_fill, s3_v_r && adv |=> out_tvalid, "result lost at output register")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Direction codes carried on in_tuser.
  localparam logic ACT_DATE_TO_NUM = 1'b0;
  localparam logic ACT_NUM_TO_DATE = 1'b1;

  // Calendar range of the converter.
  localparam int FIRST_YEAR     = 1970;
  localparam int LAST_YEAR      = 2099;
  localparam int MAX_DAY_NUMBER = 47481;

  localparam int ITEMS_PER_PHASE = 350;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int TAIL_CYCLES     = 20;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic        action;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] count;
  } conv_request_t;

  typedef struct packed {
    logic [15:0] day_number;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic        error;
  } conv_result_t;

  typedef struct packed {
    conv_request_t req;
    logic          fixed;
    conv_result_t  want;
  } directed_row_t;

  localparam conv_result_t ERROR_RESULT = '{16'd0, 5'd0, 4'd0, 12'd0, 1'b1};
  localparam conv_result_t NO_RESULT    = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  // Typed expectation travelling with the request currently on the bus.
  logic         checked_fixed = 1'b0;
  conv_result_t checked_want = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int result_index = 0;

  conv_result_t expected_conversions[$];
  conv_result_t observed;
  conv_result_t predicted;

  civil_date_day_number_convert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Directed requests: extremes, every error check and both directions.
  directed_row_t directed_rows [24] = '{
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd1, 16'd1970, 16'd0}, 1'b1,
      '{16'd0, 5'd1, 4'd1, 12'd1970, 1'b0}},
    '{'{ACT_NUM_TO_DATE, 5'd0, 4'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, 5'd1, 4'd1, 12'd1970, 1'b0}},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd12, 16'd2099, 16'd0}, 1'b1,
      '{16'd47481, 5'd31, 4'd12, 12'd2099, 1'b0}},
    '{'{ACT_NUM_TO_DATE, 5'd0, 4'd0, 16'd0, 16'd47481}, 1'b1,
      '{16'd47481, 5'd31, 4'd12, 12'd2099, 1'b0}},
    '{'{ACT_NUM_TO_DATE, 5'd1, 4'd1, 16'd1970, 16'd47482}, 1'b1, ERROR_RESULT},
    '{'{ACT_NUM_TO_DATE, 5'd1, 4'd1, 16'd1970, 16'd65535}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd12, 16'd1969, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd1, 16'd2100, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd1, 16'd0, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd1, 16'd65535, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd0, 16'd2000, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd1, 4'd13, 16'd2000, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd15, 16'd2000, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd0, 4'd6, 16'd2000, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd4, 16'd1970, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd29, 4'd2, 16'd2001, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd30, 4'd2, 16'd2000, 16'd0}, 1'b1, ERROR_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd29, 4'd2, 16'd2000, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd29, 4'd2, 16'd1972, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd1, 16'd1970, 16'd65535}, 1'b0, NO_RESULT},
    '{'{ACT_NUM_TO_DATE, 5'd31, 4'd15, 16'd65535, 16'd730}, 1'b0, NO_RESULT},
    '{'{ACT_NUM_TO_DATE, 5'd0, 4'd0, 16'd0, 16'd789}, 1'b0, NO_RESULT},
    '{'{ACT_DATE_TO_NUM, 5'd31, 4'd12, 16'd2096, 16'd0}, 1'b0, NO_RESULT},
    '{'{ACT_NUM_TO_DATE, 5'd0, 4'd0, 16'd0, 16'd365}, 1'b0, NO_RESULT}
  };

  // Length of month m in year y; zero for a month outside 1 to 12.
  function automatic int month_days(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (y % 4 == 0) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Expected result of one request.
  function automatic conv_result_t convert_calendar(input conv_request_t req);
    conv_result_t r;
    int y;
    int num;
    int rest;
    int yy;
    int mm;
    r = '0;
    y = int'(req.year);
    if (req.action == ACT_DATE_TO_NUM) begin
      if (y < FIRST_YEAR || y > LAST_YEAR || req.month < 1 || req.month > 12 ||
          req.day < 1 || req.day > month_days(req.month, y)) begin
        r.error = 1'b1;
      end else begin
        num = (y - FIRST_YEAR) * 365 + (y - FIRST_YEAR + 1) / 4;
        for (mm = 1; mm < req.month; mm++)
          num += month_days(mm, y);
        num += int'(req.day) - 1;
        r.day_number = num[15:0];
        r.day = req.day;
        r.month = req.month;
        r.year = y[11:0];
      end
    end else if (int'(req.count) > MAX_DAY_NUMBER) begin
      r.error = 1'b1;
    end else begin
      rest = int'(req.count);
      yy = FIRST_YEAR;
      mm = 1;
      while (yy < LAST_YEAR && rest >= ((yy % 4 == 0) ? 366 : 365)) begin
        rest -= (yy % 4 == 0) ? 366 : 365;
        yy++;
      end
      while (mm < 12 && rest >= month_days(mm, yy)) begin
        rest -= month_days(mm, yy);
        mm++;
      end
      r.day_number = req.count;
      r.year = yy[11:0];
      r.month = mm[3:0];
      r.day = 5'(rest + 1);
    end
    return r;
  endfunction

  // Mostly well-formed dates and day numbers, the rest broken or raw noise.
  function automatic conv_request_t random_request();
    conv_request_t req;
    int kind;
    int len;
    kind = $urandom_range(19, 0);
    req.action = ACT_DATE_TO_NUM;
    req.year = 16'($urandom_range(LAST_YEAR, FIRST_YEAR));
    req.month = 4'($urandom_range(12, 1));
    len = month_days(req.month, req.year);
    req.day = 5'($urandom_range(len, 1));
    req.count = 16'($urandom);
    if (kind == 7) begin
      // Month edges, where a leap February matters most.
      req.day = $urandom_range(1, 0) ? 5'(len) : 5'd1;
    end else if (kind >= 8 && kind <= 13) begin
      req.action = ACT_NUM_TO_DATE;
      req.day = 5'($urandom);
      req.month = 4'($urandom);
      req.year = 16'($urandom);
      if (kind == 13)
        req.count = 16'($urandom_range(MAX_DAY_NUMBER, MAX_DAY_NUMBER - 400));
      else
        req.count = 16'($urandom_range(MAX_DAY_NUMBER, 0));
    end else if (kind == 14 || kind == 15) begin
      // A valid date with one field pushed out of range.
      case ($urandom_range(2, 0))
        0: req.year = $urandom_range(1, 0) ? 16'($urandom_range(FIRST_YEAR - 1, 0)) :
                      16'($urandom_range(65535, LAST_YEAR + 1));
        1: req.month = ($urandom_range(3, 0) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
        default: req.day = (len == 31 || $urandom_range(1, 0)) ? 5'd0 :
                           5'($urandom_range(31, len + 1));
      endcase
    end else if (kind == 16) begin
      req.action = ACT_NUM_TO_DATE;
      req.count = 16'($urandom_range(65535, MAX_DAY_NUMBER + 1));
    end else if (kind >= 17) begin
      req = conv_request_t'({$urandom, $urandom});
    end
    return req;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch: %s", msg);
  endfunction

  // Presents one request, after a random gap, and returns at the edge that takes it.
  task automatic send_request(input conv_request_t req, input logic fixed,
                              input conv_result_t want);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req.action;
    in_tdata <= {7'd0, req.count, req.year, req.month, req.day};
    checked_fixed <= fixed;
    checked_want <= want;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // Holds the sender off until every outstanding request has its result.
  task automatic wait_for_results();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_conversions.size() != 0 && waited < DRAIN_LIMIT);
    if (expected_conversions.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_conversions.size()));
      expected_conversions.delete();
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Records each accepted request and checks each accepted result against the oldest.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (checked_fixed)
          expected_conversions.push_back(checked_want);
        else
          expected_conversions.push_back(convert_calendar('{in_tuser, in_tdata[4:0],
              in_tdata[8:5], in_tdata[24:9], in_tdata[40:25]}));
      end
      if (out_tvalid && out_tready) begin
        observed = '{out_tdata[15:0], out_tdata[20:16], out_tdata[24:21],
                     out_tdata[36:25], out_tuser};
        if (expected_conversions.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no request outstanding",
                                 result_index));
        end else begin
          predicted = expected_conversions.pop_front();
          if (observed !== predicted)
            note_failure($sformatf({"result %0d: expected num=%0d day=%0d month=%0d ",
                "year=%0d err=%0b, got num=%0d day=%0d month=%0d year=%0d err=%0b"},
                result_index, predicted.day_number, predicted.day, predicted.month,
                predicted.year, predicted.error, observed.day_number, observed.day,
                observed.month, observed.year, observed.error));
        end
        result_index++;
      end
    end
  end

  // Stimulus: directed rows, then four random phases with different idling.
  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    send_pcts = '{0, 77, 0, 36};
    recv_pcts = '{0, 0, 77, 36};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);
    wait_for_results();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_request(random_request(), 1'b0, NO_RESULT);
      wait_for_results();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS civil_date_day_number_convert_core");
    else
      $display("FAIL civil_date_day_number_convert_core");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("FAIL civil_date_day_number_convert_core");
    $finish;
  end

endmodule
